/* sv/tctt_pkg.sv */
// ----------------------------------------------------------------------------
// tctt_pkg
// Shared types and constants for the tagged countdown timer table.
// ----------------------------------------------------------------------------
package tctt_pkg;

  localparam int SLOTS     = 16;
  localparam int TAG_BITS  = 16;
  localparam int TIME_BITS = 24;
  localparam int CMD_BITS  = 3;

  // Command codes on command_i
  localparam logic [CMD_BITS-1:0] CMD_ADD     = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_TICK    = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_CANCEL  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_ABANDON = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 3'd4;

  // Result kind codes
  localparam logic RES_FIRED = 1'b0;
  localparam logic RES_ACK   = 1'b1;

  // Add status codes
  localparam logic ADD_OK   = 1'b0;
  localparam logic ADD_FULL = 1'b1;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ADD,
    CELL_TICK,
    CELL_CANCEL,
    CELL_ABANDON,
    CELL_CLEAR,
    CELL_REMOVE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_REMOVE
  } state_e;

  typedef struct packed {
    logic                 valid;
    logic                 kill;
    logic [TIME_BITS-1:0] remaining;
    logic [TAG_BITS-1:0]  tag;
  } slot_t;

  typedef struct packed {
    cell_op_e             op;
    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] elapsed;
  } ctrl_t;

  // Scan carried down the row: hole seen above, tag of the first marked
  // timer, and a saturating count (0, 1, 2+) of marked timers.
  typedef struct packed {
    logic                hole;
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          kills;
  } scan_t;

endpackage

/* sv/tagged_countdown_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// tagged_countdown_timer_table_unit
// Table of countdown timers kept newest first, built as a row of slot cells.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low. Add, abandon and
// clear are done in the cycle they are taken; an add answers with one
// acknowledge beat on the cycle after it is taken. Tick and cancel count down
// and mark timers in every slot at once in the cycle they are taken, then
// enter removal, where busy_o is high and the row closes up behind the first
// marked timer, one timer per cycle; removal is entered even when no timer is
// marked. Each fired timer gives one beat, newest first, registered in the
// cycle after its removal,
// and the final beat of a run carries last_of_run_o. Beats appear on
// result_valid_o for exactly one cycle and the receiver cannot hold them off,
// so it must take every beat as it comes.
// ----------------------------------------------------------------------------
module tagged_countdown_timer_table_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [tctt_pkg::CMD_BITS-1:0]  command_i,
  input  logic [tctt_pkg::TIME_BITS-1:0] delay_i,
  input  logic [tctt_pkg::TAG_BITS-1:0]  tag_i,
  input  logic [tctt_pkg::TIME_BITS-1:0] elapsed_i,
  output logic                           result_valid_o,
  output logic                           result_kind_o,
  output logic [tctt_pkg::TAG_BITS-1:0]  fired_tag_o,
  output logic                           add_status_o,
  output logic                           last_of_run_o
);
  import tctt_pkg::*;

  state_e              state_q, state_d;
  logic                emit_q, emit_d;
  logic                accept;
  logic                full;
  ctrl_t               ctrl;
  slot_t               new_entry;
  slot_t               entries [SLOTS];
  scan_t               scans [SLOTS+1];
  scan_t               scan_end;
  logic                any_kill, more_kill;
  logic [SLOTS-1:0]    valid_vec;

  // result beat register
  logic                res_valid_q, res_valid_d;
  logic                res_kind_q, res_kind_d;
  logic [TAG_BITS-1:0] res_tag_q, res_tag_d;
  logic                res_status_q, res_status_d;
  logic                res_last_q, res_last_d;

  assign accept    = start_i && !busy_o;
  assign full      = entries[SLOTS-1].valid;
  assign scan_end  = scans[SLOTS];
  assign any_kill  = (scan_end.kills != 2'd0);
  assign more_kill = (scan_end.kills == 2'd2);
  assign new_entry = '{valid: 1'b1, kill: 1'b0, remaining: delay_i, tag: tag_i};
  assign scans[0]  = '{hole: 1'b0, tag: '0, kills: 2'd0};

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      valid_vec[i] = entries[i].valid;
    end
  end

  // Row of slot cells: slot 0 is the newest timer
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    slot_t prev_s, next_s;
    if (g == 0) begin : g_head
      assign prev_s = new_entry;
    end else begin : g_mid_prev
      assign prev_s = entries[g-1];
    end
    if (g == SLOTS-1) begin : g_tail
      assign next_s = '0;
    end else begin : g_mid_next
      assign next_s = entries[g+1];
    end
    tctt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .prev_i  (prev_s),
      .next_i  (next_s),
      .scan_i  (scans[g]),
      .entry_o (entries[g]),
      .scan_o  (scans[g+1])
    );
  end

  // Next state: stay in removal while a second marked timer remains
  always_comb begin
    state_d = state_q;
    emit_d  = emit_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && ((command_i == CMD_TICK) || (command_i == CMD_CANCEL))) begin
          state_d = ST_REMOVE;
          emit_d  = (command_i == CMD_TICK);
        end
      end
      ST_REMOVE: begin
        if (!more_kill) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: busy flag and the operation for every cell
  always_comb begin
    busy_o       = (state_q != ST_IDLE);
    ctrl.op      = CELL_HOLD;
    ctrl.tag     = tag_i;
    ctrl.elapsed = elapsed_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_ADD:     ctrl.op = full ? CELL_HOLD : CELL_ADD;
            CMD_TICK:    ctrl.op = CELL_TICK;
            CMD_CANCEL:  ctrl.op = CELL_CANCEL;
            CMD_ABANDON: ctrl.op = CELL_ABANDON;
            CMD_CLEAR:   ctrl.op = CELL_CLEAR;
            default:     ctrl.op = CELL_HOLD;
          endcase
        end
      end
      ST_REMOVE: ctrl.op = CELL_REMOVE;
      default:   ctrl.op = CELL_HOLD;
    endcase
  end

  // Build the next result beat: an add acknowledge or a fired timer
  always_comb begin
    res_valid_d  = 1'b0;
    res_kind_d   = RES_FIRED;
    res_tag_d    = '0;
    res_status_d = ADD_OK;
    res_last_d   = 1'b0;
    if (accept && (command_i == CMD_ADD)) begin
      res_valid_d  = 1'b1;
      res_kind_d   = RES_ACK;
      res_status_d = full ? ADD_FULL : ADD_OK;
      res_last_d   = 1'b1;
    end else if ((state_q == ST_REMOVE) && any_kill && emit_q) begin
      res_valid_d = 1'b1;
      res_tag_d   = scan_end.tag;
      res_last_d  = !more_kill;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      emit_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_q      <= emit_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q   <= res_kind_d;
    res_tag_q    <= res_tag_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_kind_o  = res_kind_q;
  assign fired_tag_o    = res_tag_q;
  assign add_status_o   = res_status_q;
  assign last_of_run_o  = res_last_q;

  // Live timers always sit packed at the head of the row
  a_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, valid_vec} + {{SLOTS{1'b0}}, 1'b1}))
    else $error("live timers are not packed at the head");

  // An accepted add answers with exactly one final acknowledge beat
  a_add_ack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_ADD)) |=>
      (result_valid_o && (result_kind_o == RES_ACK) && last_of_run_o))
    else $error("add was not acknowledged");

  // Fired beats come only out of a removal cycle of a tick
  a_fire_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_kind_o == RES_FIRED)) |->
      ($past(state_q) == ST_REMOVE) && $past(emit_q))
    else $error("fired beat outside a tick removal");

  // Removal ends once no further marked timer is left
  a_remove_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_REMOVE) && !more_kill) |=> (state_q == ST_IDLE))
    else $error("removal did not finish");

endmodule

/* sv/tctt_cell.sv */
// ----------------------------------------------------------------------------
// tctt_cell
// One timer slot: holds a timer, counts it down, marks it for removal and
// closes the gap left by the first marked timer above or at it.
// ----------------------------------------------------------------------------
module tctt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tctt_pkg::ctrl_t ctrl_i,
  input  tctt_pkg::slot_t prev_i,
  input  tctt_pkg::slot_t next_i,
  input  tctt_pkg::scan_t scan_i,
  output tctt_pkg::slot_t entry_o,
  output tctt_pkg::scan_t scan_o
);
  import tctt_pkg::*;

  logic                 valid_q, valid_d;
  logic                 kill_q, kill_d;
  logic [TIME_BITS-1:0] remaining_q, remaining_d;
  logic [TAG_BITS-1:0]  tag_q, tag_d;
  logic                 kill_v;

  assign entry_o = '{valid: valid_q, kill: kill_q, remaining: remaining_q, tag: tag_q};
  assign kill_v  = valid_q & kill_q;

  always_comb begin
    scan_o.hole = scan_i.hole | kill_v;
    scan_o.tag  = (kill_v && !scan_i.hole) ? tag_q : scan_i.tag;
    if (kill_v && (scan_i.kills != 2'd2)) begin
      scan_o.kills = scan_i.kills + 2'd1;
    end else begin
      scan_o.kills = scan_i.kills;
    end
  end

  always_comb begin
    valid_d     = valid_q;
    kill_d      = kill_q;
    remaining_d = remaining_q;
    tag_d       = tag_q;
    case (ctrl_i.op)
      CELL_ADD: begin
        valid_d     = prev_i.valid;
        kill_d      = prev_i.kill;
        remaining_d = prev_i.remaining;
        tag_d       = prev_i.tag;
      end
      CELL_TICK: begin
        if (remaining_q > ctrl_i.elapsed) begin
          remaining_d = remaining_q - ctrl_i.elapsed;
          kill_d      = 1'b0;
        end else begin
          kill_d = 1'b1;
        end
      end
      CELL_CANCEL:  kill_d = (tag_q == ctrl_i.tag);
      CELL_ABANDON: remaining_d = '0;
      CELL_CLEAR:   valid_d = 1'b0;
      CELL_REMOVE: begin
        // pull up from below once the first marked timer is at or above
        if (scan_o.hole) begin
          valid_d     = next_i.valid;
          kill_d      = next_i.kill;
          remaining_d = next_i.remaining;
          tag_d       = next_i.tag;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      kill_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      kill_q  <= kill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remaining_q <= remaining_d;
    tag_q       <= tag_d;
  end

endmodule
